// ===== hw/rtl/gplm_pkg.sv =====
package gplm_pkg;

  // Sample format codes
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;
  localparam logic [1:0] FMT_RAW = 2'd3;

  // Configuration register indexes
  localparam logic CFG_SAMPLE_FORMAT = 1'b0;
  localparam logic CFG_GAIN_PERCENT  = 1'b1;

  localparam int CFG_DATA_W = 10;

  localparam logic [1:0]            FORMAT_RESET = FMT_S16;
  localparam logic [CFG_DATA_W-1:0] GAIN_RESET   = 10'd100;
  localparam logic [CFG_DATA_W-1:0] GAIN_UNITY   = 10'd100;

  // floor(x/100) = (x * RECIP100) >> 37 for any 32-bit x
  localparam logic [31:0] RECIP100 = 32'h51EB_851F;
  // floor(x/100) = (x * RECIP100_NARROW) >> 24 for x below 2^17
  localparam logic [17:0] RECIP100_NARROW = 18'd167773;
  // floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  localparam logic [30:0] PEAK_MAX = 31'h7FFF_FFFF;

  // Smallest top-bits index that reaches reading 1 .. 9
  localparam logic [6:0] LEVEL_STEPS [9] = '{7'd2, 7'd3, 7'd5, 7'd8, 7'd13,
                                             7'd21, 7'd34, 7'd55, 7'd91};

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } gplm_item_t;

  function automatic logic [3:0] level_of(input logic [6:0] idx);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (idx >= LEVEL_STEPS[i]) begin
        r = 4'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gplm_gain.sv =====
module gplm_gain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           sample_format,
  input  logic [9:0]           gain_percent,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_sample_bits,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gplm_pkg::gplm_item_t out_item
);
  import gplm_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic take1, take2, take3, take4;

  // stage 1: sample, sign and magnitude
  logic [31:0] raw1_r, mag1_r;
  logic        neg1_r, last1_r;
  // stage 2: magnitude / 100
  logic [31:0] raw2_r, mag2_r;
  logic        neg2_r, last2_r;
  logic [24:0] q2_r;
  // stage 3: partial products with the gain
  logic [31:0] raw3_r, phi3_r;
  logic [16:0] plo3_r;
  logic        neg3_r, last3_r;
  // stage 4: result word
  logic [31:0] word4_r;
  logic        last4_r;

  logic [31:0] s_ext, mag_in;
  logic [63:0] prod_q;
  logic [31:0] rem_full;
  logic [6:0]  rem;
  logic [34:0] phi_full;
  logic [16:0] plo;
  logic [34:0] lo_prod;
  logic [9:0]  lo_q;
  logic [31:0] sum, res;
  logic        scale;

  assign take4 = !v4_r || !out_stall;
  assign take3 = !v3_r || take4;
  assign take2 = !v2_r || take3;
  assign take1 = !v1_r || take2;
  assign in_stall = !take1;

  always_comb begin
    s_ext  = (sample_format == FMT_S16) ?
             {{16{in_sample_bits[15]}}, in_sample_bits[15:0]} : in_sample_bits;
    mag_in = s_ext[31] ? (~s_ext + 32'd1) : s_ext;
  end

  assign prod_q   = {32'd0, mag1_r} * {32'd0, RECIP100};
  assign rem_full = mag2_r - ({7'd0, q2_r} * 32'd100);
  assign rem      = rem_full[6:0];
  assign phi_full = {10'd0, q2_r} * {25'd0, gain_percent};
  assign plo      = {10'd0, rem} * {7'd0, gain_percent};
  assign lo_prod  = {18'd0, plo3_r} * {17'd0, RECIP100_NARROW};
  assign lo_q     = lo_prod[33:24];
  assign sum      = phi3_r + {22'd0, lo_q};
  assign res      = neg3_r ? (~sum + 32'd1) : sum;
  assign scale    = (gain_percent != '0) && (gain_percent != GAIN_UNITY) &&
                    ((sample_format == FMT_S16) || (sample_format == FMT_S32));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (take1) v1_r <= in_valid;
      if (take2) v2_r <= v1_r;
      if (take3) v3_r <= v2_r;
      if (take4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      raw1_r  <= in_sample_bits;
      mag1_r  <= mag_in;
      neg1_r  <= s_ext[31];
      last1_r <= in_last;
    end
    if (take2) begin
      raw2_r  <= raw1_r;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      last2_r <= last1_r;
      q2_r    <= prod_q[61:37];
    end
    if (take3) begin
      raw3_r  <= raw2_r;
      phi3_r  <= phi_full[31:0];
      plo3_r  <= plo;
      neg3_r  <= neg2_r;
      last3_r <= last2_r;
    end
    if (take4) begin
      word4_r <= scale ? res : raw3_r;
      last4_r <= last3_r;
    end
  end

  assign out_valid     = v4_r;
  assign out_item.word = word4_r;
  assign out_item.last = last4_r;

endmodule

// ===== hw/rtl/gplm_meter.sv =====
module gplm_meter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           sample_format,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gplm_pkg::gplm_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_scaled_bits,
  output logic                 out_meter_valid,
  output logic [3:0]           out_meter_reading
);
  import gplm_pkg::*;

  logic v5_r, v6_r;
  logic take5, take6;

  logic [31:0] scaled5_r;
  logic [30:0] mag5_r;
  logic        last5_r, bypass5_r;

  logic [31:0] scaled6_r;
  logic        mvalid6_r;
  logic [3:0]  reading6_r;
  logic [30:0] peak_r, peak_nxt;

  logic [31:0] scaled, aligned, abs_al;
  logic [30:0] mag;
  logic [30:0] peak_max;
  logic [62:0] prod_d;
  logic [30:0] decayed;

  assign take6    = !v6_r || !out_stall;
  assign take5    = !v5_r || take6;
  assign in_stall = !take5;

  // align to 32 bits per format and take the saturated magnitude
  always_comb begin
    case (sample_format)
      FMT_U8: begin
        scaled  = {24'd0, in_item.word[7:0]};
        aligned = {in_item.word[7] ^ 1'b1, in_item.word[6:0], 24'd0};
      end
      FMT_S16: begin
        scaled  = {16'd0, in_item.word[15:0]};
        aligned = {in_item.word[15:0], 16'd0};
      end
      default: begin
        scaled  = in_item.word;
        aligned = in_item.word;
      end
    endcase
    abs_al = aligned[31] ? (~aligned + 32'd1) : aligned;
    mag    = abs_al[31] ? PEAK_MAX : abs_al[30:0];
  end

  assign peak_max = (mag5_r > peak_r) ? mag5_r : peak_r;
  assign prod_d   = {32'd0, peak_max} * {31'd0, RECIP3};
  assign decayed  = {prod_d[62:33], 1'b0};

  always_comb begin
    peak_nxt = peak_r;
    if (v5_r && take6 && !bypass5_r) begin
      peak_nxt = last5_r ? decayed : peak_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      peak_r <= '0;
    end else begin
      if (take5) v5_r <= in_valid;
      if (take6) v6_r <= v5_r;
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take5) begin
      scaled5_r <= scaled;
      mag5_r    <= mag;
      last5_r   <= in_item.last;
      bypass5_r <= (sample_format == FMT_RAW);
    end
    if (take6) begin
      scaled6_r  <= scaled5_r;
      mvalid6_r  <= last5_r && !bypass5_r;
      reading6_r <= (last5_r && !bypass5_r) ? level_of(peak_max[30:24]) : 4'd0;
    end
  end

  assign out_valid         = v6_r;
  assign out_scaled_bits   = scaled6_r;
  assign out_meter_valid   = mvalid6_r;
  assign out_meter_reading = reading6_r;

endmodule

// ===== hw/rtl/gain_and_peak_level_meter_core.sv =====
// Gain and peak level meter core.
// Input channel (in_valid / in_stall): one audio sample a beat, in_sample_bits
// holding the raw pattern (low 8, 16 or 32 bits used per format) and
// in_last_in_block marking the final sample of a block.
// Result channel (out_valid / out_stall): one beat per input beat, in order,
// carrying the sample after gain (signed formats) and, on a block's last
// sample outside raw format, a meter reading with out_meter_valid set.
// Configuration (cfg_we / cfg_index / cfg_wdata): write sample_format (index 0)
// and gain_percent (index 1) only while the block is idle.
// Throughput: one beat per cycle while out_stall is low. Pipeline: six register
// stages, four of gain arithmetic (magnitude, divide by 100 through a reciprocal
// multiply, gain products, recombine) and two of metering (alignment and
// magnitude, then peak update).
// The peak register is the only loop: compare, lookup and decay by 2/3 (one
// reciprocal multiply) are combinational logic off its output.
// Reset: all pipeline stages empty, peak cleared, format signed 16-bit, gain 100.
// Stall: a stalled result holds; earlier stages keep filling bubbles, so input
// beats are still taken until the pipeline is full.
module gain_and_peak_level_meter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [gplm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_bits,
  input  logic        in_last_in_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_scaled_bits,
  output logic        out_meter_valid,
  output logic [3:0]  out_meter_reading
);
  import gplm_pkg::*;

  logic [1:0]            sample_format_r;
  logic [CFG_DATA_W-1:0] gain_percent_r;

  logic       mid_valid, mid_stall;
  gplm_item_t mid_item;

  // Register writes: decode the index, drop the rest of the data word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_format_r <= FORMAT_RESET;
      gain_percent_r  <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_FORMAT: sample_format_r <= cfg_wdata[1:0];
        CFG_GAIN_PERCENT:  gain_percent_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Gain arithmetic: truncating multiply by gain/100, wrapped to the sample width
  gplm_gain u_gain (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_format  (sample_format_r),
    .gain_percent   (gain_percent_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_bits (in_sample_bits),
    .in_last        (in_last_in_block),
    .out_valid      (mid_valid),
    .out_stall      (mid_stall),
    .out_item       (mid_item)
  );

  // Metering: align, magnitude, peak hold, reading and decay
  gplm_meter u_meter (
    .clk               (clk),
    .rst_n             (rst_n),
    .sample_format     (sample_format_r),
    .in_valid          (mid_valid),
    .in_stall          (mid_stall),
    .in_item           (mid_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scaled_bits   (out_scaled_bits),
    .out_meter_valid   (out_meter_valid),
    .out_meter_reading (out_meter_reading)
  );

endmodule

// ===== bench/gain_and_peak_level_meter_core_tb.sv =====
module gain_and_peak_level_meter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gplm_pkg::*;

  // Pipeline depth given for the core; used for the tail wait only
  localparam int PIPE_LATENCY = 6;
  // Watchdog limit, set with a wide margin over the slowest run
  localparam int CYCLE_LIMIT  = 500_000;

  typedef struct {
    logic [31:0] scaled;
    logic        meter_valid;
    logic [3:0]  reading;
  } meter_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [31:0]           in_sample_bits = '0;
  logic                  in_last_in_block = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [31:0]           out_scaled_bits;
  logic                  out_meter_valid;
  logic [3:0]            out_meter_reading;

  // Own copy of the core's state and registers
  logic [1:0]            model_format = FMT_S16;
  logic [9:0]            model_gain = 10'd100;
  logic [30:0]           model_peak = '0;

  meter_beat_t           pending_beats[$];
  int unsigned           error_count = 0;
  int unsigned           cycle_count = 0;

  // Idling switches; cleared for stretches of back-to-back traffic
  bit                    send_idle_en = 1'b1;
  bit                    recv_idle_en = 1'b1;
  int unsigned           hold_left = 0;

  gain_and_peak_level_meter_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_bits    (in_sample_bits),
    .in_last_in_block  (in_last_in_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scaled_bits   (out_scaled_bits),
    .out_meter_valid   (out_meter_valid),
    .out_meter_reading (out_meter_reading)
  );

  always #10 clk = ~clk;

  // Rough 5*log10 level from the top seven peak bits
  function automatic logic [3:0] level_from_top(input logic [6:0] top);
    if (top >= 7'd91) return 4'd9;
    if (top >= 7'd55) return 4'd8;
    if (top >= 7'd34) return 4'd7;
    if (top >= 7'd21) return 4'd6;
    if (top >= 7'd13) return 4'd5;
    if (top >= 7'd8)  return 4'd4;
    if (top >= 7'd5)  return 4'd3;
    if (top >= 7'd3)  return 4'd2;
    if (top >= 7'd2)  return 4'd1;
    return 4'd0;
  endfunction

  // Work out the result beat for one accepted sample and advance the peak
  function automatic void predict_meter_beat(input logic [31:0] word, input logic last,
                                             output meter_beat_t beat);
    longint signed s;
    longint signed prod;
    longint signed aligned;
    longint signed mag;
    logic [15:0]   w16;
    logic [31:0]   w32;
    logic          scale;
    scale = (model_gain != 10'd0) && (model_gain != 10'd100);
    beat.meter_valid = 1'b0;
    beat.reading = 4'd0;
    case (model_format)
      FMT_U8: begin
        // Offset binary, never scaled
        beat.scaled = {24'b0, word[7:0]};
        aligned = (longint'(word[7:0]) - 128) * (longint'(1) << 24);
      end
      FMT_S16: begin
        s = longint'($signed(word[15:0]));
        if (scale) begin
          // Truncate toward zero, then wrap to 16 bits
          prod = (s * longint'(model_gain)) / 100;
          w16 = prod[15:0];
          s = longint'($signed(w16));
        end
        beat.scaled = {16'b0, s[15:0]};
        aligned = s * 65536;
      end
      FMT_S32: begin
        s = longint'($signed(word));
        if (scale) begin
          prod = (s * longint'(model_gain)) / 100;
          w32 = prod[31:0];
          s = longint'($signed(w32));
        end
        beat.scaled = s[31:0];
        aligned = s;
      end
      default: begin
        // Raw pass: peak untouched, no meter even on a block end
        beat.scaled = word;
        return;
      end
    endcase
    mag = (aligned < 0) ? -aligned : aligned;
    if (mag > 64'sh7FFF_FFFF) mag = 64'sh7FFF_FFFF;
    if (mag[30:0] > model_peak) model_peak = mag[30:0];
    if (last) begin
      beat.meter_valid = 1'b1;
      beat.reading = level_from_top(model_peak[30:24]);
      model_peak = 31'((model_peak / 3) * 2);
    end
  endfunction

  // Hold the beat until the core takes it, then log the expected result
  task automatic send_sample(input logic [31:0] word, input logic last);
    int unsigned gap;
    meter_beat_t beat;
    gap = send_idle_en ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_bits <= word;
    in_last_in_block <= last;
    do @(posedge clk); while (in_stall);
    predict_meter_beat(word, last, beat);
    pending_beats.push_back(beat);
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  // One register write; call only with the core idle
  task automatic write_config(input logic idx, input logic [9:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SAMPLE_FORMAT) model_format = value[1:0];
    else model_gain = value;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
    error_count++;
    $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, exp_val,
             act_val);
  endtask

  // Result side: compare each taken beat with the oldest expectation,
  // then draw how long to stall before the next one
  always @(posedge clk) begin
    meter_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_beats.size() == 0) begin
          report_mismatch("unexpected beat, scaled", 32'h0, out_scaled_bits);
        end else begin
          want = pending_beats.pop_front();
          if (out_scaled_bits !== want.scaled)
            report_mismatch("scaled_bits", want.scaled, out_scaled_bits);
          if (out_meter_valid !== want.meter_valid)
            report_mismatch("meter_valid", {31'b0, want.meter_valid}, {31'b0, out_meter_valid});
          if (out_meter_reading !== want.reading)
            report_mismatch("meter_reading", {28'b0, want.reading}, {28'b0, out_meter_reading});
        end
        hold_left = recv_idle_en ? $urandom_range(0, 9) : 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Registers straight out of reset: signed 16-bit, unity gain
  task automatic test_reset_defaults();
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'hFFFF_8000, 1'b0);   // most negative saturates the magnitude
    send_sample(32'hABCD_0000, 1'b0);
    send_sample(32'h1234_FFFF, 1'b1);
    wait_for_drain();
  endtask

  // Offset-binary bytes pass through whatever the gain
  task automatic test_unsigned_bytes();
    write_config(CFG_SAMPLE_FORMAT, {8'b0, FMT_U8});
    write_config(CFG_GAIN_PERCENT, 10'd250);
    send_sample(32'hFFFF_FF00, 1'b0);
    send_sample(32'h0000_0080, 1'b0);
    send_sample(32'h1234_56FF, 1'b0);
    send_sample(32'h0000_007F, 1'b1);
    wait_for_drain();
  endtask

  // Top gain wraps, zero gain passes, 1% gain truncates toward zero
  task automatic test_s16_gain_extremes();
    write_config(CFG_SAMPLE_FORMAT, {8'b0, FMT_S16});
    write_config(CFG_GAIN_PERCENT, 10'd1023);
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'h5555_8000, 1'b1);
    wait_for_drain();
    write_config(CFG_GAIN_PERCENT, 10'd0);
    send_sample(32'h0000_8001, 1'b1);
    wait_for_drain();
    write_config(CFG_GAIN_PERCENT, 10'd1);
    send_sample(32'h0000_0063, 1'b0);
    send_sample(32'hFFFF_FF9D, 1'b1);
    wait_for_drain();
  endtask

  // Full-width samples: saturation at the most negative value, large gain
  task automatic test_s32_saturation();
    write_config(CFG_SAMPLE_FORMAT, {8'b0, FMT_S32});
    write_config(CFG_GAIN_PERCENT, 10'd100);
    send_sample(32'h8000_0000, 1'b1);
    wait_for_drain();
    write_config(CFG_GAIN_PERCENT, 10'd1000);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0001, 1'b0);
    send_sample(32'h0147_AE14, 1'b1);
    wait_for_drain();
  endtask

  // Format code 3: words pass whole and the peak is left alone
  task automatic test_raw_pass();
    write_config(CFG_SAMPLE_FORMAT, {8'b0, FMT_RAW});
    send_sample(32'hDEAD_BEEF, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    wait_for_drain();
    write_config(CFG_SAMPLE_FORMAT, {8'b0, FMT_S16});
    write_config(CFG_GAIN_PERCENT, 10'd100);
    send_sample(32'h0000_0000, 1'b1);
    wait_for_drain();
  endtask

  // Full-scale peak, then silent blocks to watch the 2/3 decay
  task automatic test_peak_decay();
    write_config(CFG_SAMPLE_FORMAT, {8'b0, FMT_S32});
    send_sample(32'h7FFF_FFFF, 1'b1);
    repeat (3) send_sample(32'h0000_0000, 1'b1);
    wait_for_drain();
  endtask

  function automatic logic [9:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'd100;
      2: return 10'd1023;
      3: return 10'd1000;
      4: return 10'd1;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // Mix of full-range words, corner patterns and scaled-down amplitudes; the
  // first two mostly keep random upper bits so unused lanes still toggle
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        case ($urandom_range(0, 5))
          0: w[15:0] = 16'h7FFF;
          1: w[15:0] = 16'h8000;
          2: w = 32'h8000_0000;
          3: w = 32'h7FFF_FFFF;
          4: w[7:0] = 8'h00;
          default: w[7:0] = 8'hFF;
        endcase
      end
      default: begin
        w = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) w = -w;
      end
    endcase
    return w;
  endfunction

  // Phases of random blocks under random settings and idling patterns
  task automatic test_random_blocks();
    int unsigned block_left;
    logic [1:0]  fmt;
    for (int phase = 0; phase < 12; phase++) begin
      wait_for_drain();
      fmt = ($urandom_range(0, 7) == 0) ? FMT_RAW : 2'($urandom_range(0, 2));
      write_config(CFG_SAMPLE_FORMAT, {8'b0, fmt});
      write_config(CFG_GAIN_PERCENT, pick_gain());
      send_idle_en = (phase % 4) != 1 && (phase % 4) != 3;
      recv_idle_en = (phase % 4) != 1 && (phase % 4) != 2;
      block_left = $urandom_range(1, 40);
      for (int n = 0; n < 100; n++) begin
        send_sample(pick_word(), block_left == 1);
        // Advance to the next block, now and then a single-sample one
        if (block_left == 1) block_left = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
        else block_left--;
      end
    end
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_unsigned_bytes();
    test_s16_gain_extremes();
    test_s32_saturation();
    test_raw_pass();
    test_peak_decay();
    test_random_blocks();

    // Drain, then let any stray beat show before the verdict
    wait_for_drain();
    repeat (PIPE_LATENCY + 20) @(posedge clk);

    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
